// ----- sv/dndq_pkg.sv -----
`default_nettype none

package dndq_pkg;

   localparam int RING_SPAN_DEFAULT            = 2450;
   localparam int DITHER_FRACTION_BITS_DEFAULT = 16;

   localparam int SAMPLE_W = 40;
   localparam int OUT_W    = 24;
   localparam int OFFSET_W = 12;
   localparam int SEED_W   = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   // sample plus dither plus delayed term, with headroom
   localparam int SUM_W = SAMPLE_W + 2;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(1);
   localparam logic [SEED_W-1:0]   SEED_RESET   = 32'd2463534242;

   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(8388608);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_OFFSET = 2'd0,
      CSR_PHASE_MODE   = 2'd1,
      CSR_NOISE_SEED   = 2'd2
   } csr_index_type;

   function automatic logic [SEED_W-1:0] next_noise(input logic [SEED_W-1:0] n);
      logic [SEED_W-1:0] t;
      t = n ^ (n << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- sv/dndq_dither_ram.sv -----
`default_nettype none

module dndq_dither_ram #(
   parameter int DEPTH  = 2451,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // read-first: a read and a write in the same cycle return the old contents
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/delayed_node_dither_quantizer_core.sv -----
`default_nettype none

// 24-bit dither quantizer with delayed-noise cancellation. Takes one sample
// per clock unless the output stalls, and returns it through the stage-1 and
// output registers; the single read/write port pair of the dither memory sets
// that rate, with each transaction reading its delayed entry and writing its
// fresh dither in the cycle it is accepted. The dither ring holds RING_SPAN+1
// entries of DITHER_FRACTION_BITS bits (the mirrored half of the classic
// layout folds onto the same entries). It needs no clearing pass after
// reset: a fill count marks which entries have been written, and unwritten
// entries read as zero, so transactions are taken from the first cycle out
// of reset. A write to noise_seed reloads the generator at once. The user must
// write configuration only while no transaction is in flight; not enforced.
module delayed_node_dither_quantizer_core #(
   parameter int RING_SPAN            = dndq_pkg::RING_SPAN_DEFAULT,
   parameter int DITHER_FRACTION_BITS = dndq_pkg::DITHER_FRACTION_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic signed [dndq_pkg::SAMPLE_W-1:0]   req_sample_in,

   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic signed [dndq_pkg::OUT_W-1:0]      rsp_sample_out,

   input  wire logic                                   csr_write_en,
   input  wire logic [dndq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [dndq_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int DEPTH = RING_SPAN + 1;
   localparam int PW    = $clog2(DEPTH);
   localparam int FW    = DITHER_FRACTION_BITS;
   localparam int SW    = dndq_pkg::SUM_W;

   localparam logic [dndq_pkg::OFFSET_W-1:0] OFF_MAX = dndq_pkg::OFFSET_W'(RING_SPAN - 10);
   localparam logic [dndq_pkg::OFFSET_W-1:0] OFF_MIN = dndq_pkg::OFFSET_W'(1);
   localparam logic [PW-1:0]  POS_TOP  = PW'(RING_SPAN);
   localparam logic [PW:0]    SPAN_EXT = (PW+1)'(RING_SPAN);
   localparam logic signed [SW-1:0] ONE_LSB = SW'(1) <<< FW;

   // configuration
   logic [dndq_pkg::OFFSET_W-1:0] delay_offset_ff;
   logic                          phase_mode_ff;
   logic [dndq_pkg::SEED_W-1:0]   noise_ff, noise_in;

   // ring control
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] fill_ff, fill_in;

   // stage 1: memory read in flight
   logic                              s1_valid_ff, s1_valid_in;
   logic signed [dndq_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic [FW-1:0]                     s1_dith_ff;
   logic                              s1_hit_ff;
   logic                              s1_phase_ff;

   // output register
   logic                              out_valid_ff, out_valid_in;
   logic signed [dndq_pkg::OUT_W-1:0] out_sample_ff;

   logic                          accept;
   logic                          out_free;
   logic                          s1_advance;
   logic [dndq_pkg::OFFSET_W-1:0] off_clamp;
   logic [PW:0]                   rd_sum;
   logic [PW-1:0]                 rd_addr;
   logic                          rd_hit;
   logic [FW-1:0]                 dith;
   logic [FW-1:0]                 rd_data;
   logic [FW-1:0]                 delayed;
   logic signed [SW-1:0]          x_sum;
   logic signed [SW-1:0]          q_val;
   logic signed [dndq_pkg::OUT_W-1:0] q_sat;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign accept     = req_valid && req_ready;

   // stage 0: delayed read address, fresh dither
   always_comb begin
      if (delay_offset_ff < OFF_MIN) begin
         off_clamp = OFF_MIN;
      end else if (delay_offset_ff > OFF_MAX) begin
         off_clamp = OFF_MAX;
      end else begin
         off_clamp = delay_offset_ff;
      end
      rd_sum = {1'b0, pos_ff} + {1'b0, PW'(off_clamp)};
      // upper mirror half folds back onto the lower entries
      if (rd_sum > SPAN_EXT) begin
         rd_addr = PW'(rd_sum - SPAN_EXT);
      end else begin
         rd_addr = PW'(rd_sum);
      end
      // ring is written from the top down after reset
      rd_hit = ({1'b0, rd_addr} + {1'b0, fill_ff}) > SPAN_EXT;
      dith   = FW'(noise_ff >> (dndq_pkg::SEED_W - FW));
   end

   dndq_dither_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (PW),
      .DATA_W (FW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (accept),
      .wr_addr (pos_ff),
      .wr_data (dith)
   );

   // stage 1: dithered sum, floor, saturate
   always_comb begin
      delayed = s1_hit_ff ? rd_data : '0;
      x_sum   = SW'(s1_sample_ff) + SW'(s1_dith_ff);
      if (s1_phase_ff) begin
         x_sum = x_sum + SW'(delayed) - ONE_LSB;
      end else begin
         x_sum = x_sum - SW'(delayed);
      end
      q_val = x_sum >>> FW;
      if (q_val > dndq_pkg::OUT_MAX) begin
         q_sat = dndq_pkg::OUT_W'(dndq_pkg::OUT_MAX);
      end else if (q_val < dndq_pkg::OUT_MIN) begin
         q_sat = dndq_pkg::OUT_W'(dndq_pkg::OUT_MIN);
      end else begin
         q_sat = dndq_pkg::OUT_W'(q_val);
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      noise_in     = noise_ff;
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (accept) begin
         pos_in   = (pos_ff == '0) ? POS_TOP : pos_ff - PW'(1);
         fill_in  = (fill_ff == POS_TOP) ? fill_ff : fill_ff + PW'(1);
         noise_in = dndq_pkg::next_noise(noise_ff);
      end
      if (csr_write_en && csr_index == dndq_pkg::CSR_NOISE_SEED) begin
         noise_in = csr_wdata;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_offset_ff <= dndq_pkg::OFFSET_RESET;
         phase_mode_ff   <= 1'b0;
         noise_ff        <= dndq_pkg::SEED_RESET;
         pos_ff          <= POS_TOP;
         fill_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               dndq_pkg::CSR_DELAY_OFFSET: delay_offset_ff <= csr_wdata[dndq_pkg::OFFSET_W-1:0];
               dndq_pkg::CSR_PHASE_MODE:   phase_mode_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         noise_ff     <= noise_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample_in;
         s1_dith_ff   <= dith;
         s1_hit_ff    <= rd_hit;
         s1_phase_ff  <= phase_mode_ff;
      end
      if (s1_advance) begin
         out_sample_ff <= q_sat;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;

   // a stalled output with stage 1 occupied must hold off new transactions
   a_stall_blocks_accept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("transaction accepted while pipeline is full");

   // the delayed read never hits the entry written in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      accept |-> (rd_addr != pos_ff))
      else $error("delayed read collides with dither write");

   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && pos_ff == '0) |=> (pos_ff == POS_TOP))
      else $error("ring position did not wrap");

   a_stage1_filled: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction lost before stage 1");

endmodule

`default_nettype wire
